[hdl/lorentz_boost_four_vector_macros.svh]
`ifndef LORENTZ_BOOST_FOUR_VECTOR_MACROS_SVH
`define LORENTZ_BOOST_FOUR_VECTOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LBFV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lorentz boost check failed");

// consequent checked in the cycle after the antecedent
`define LBFV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lorentz boost check failed");

`endif

[hdl/lbfv_pkg.sv]
package lbfv_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_BOOSTED      = 2'd0,
    ST_MOM_ZERO     = 2'd1,
    ST_ENERGY_ZERO  = 2'd2,
    ST_NOT_TIMELIKE = 2'd3
  } status_e;

  // numerator width of the boosted momentum before division
  function automatic int num_width(input int w);
    return 3 * w + 6;
  endfunction

  // divisor width, large enough for sqrt * (|E| + sqrt)
  function automatic int den_width(input int w);
    return 2 * w - 1;
  endfunction

  // cycles through the rounding divider
  function automatic int div_latency(input int w);
    return w + 2;
  endfunction

endpackage

[hdl/lorentz_boost_four_vector.sv]
// throughput: one request per cycle, busy_o stays low, the receiver cannot stall
// latency is set by the square root (one bit per stage) and the dividers (one bit per stage)
// reset: asynchronous active low, clears every valid bit; data registers are not reset
`include "lorentz_boost_four_vector_macros.svh"

module lorentz_boost_four_vector #(
  parameter int DataWidth = lbfv_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [DataWidth-1:0] particle_energy_i,
  input  logic signed [DataWidth-1:0] particle_px_i,
  input  logic signed [DataWidth-1:0] particle_py_i,
  input  logic signed [DataWidth-1:0] particle_pz_i,
  input  logic signed [DataWidth-1:0] frame_energy_i,
  input  logic signed [DataWidth-1:0] frame_px_i,
  input  logic signed [DataWidth-1:0] frame_py_i,
  input  logic signed [DataWidth-1:0] frame_pz_i,
  output logic                        valid_o,
  output logic signed [DataWidth-1:0] boosted_energy_o,
  output logic signed [DataWidth-1:0] boosted_px_o,
  output logic signed [DataWidth-1:0] boosted_py_o,
  output logic signed [DataWidth-1:0] boosted_pz_o,
  output logic [1:0]                  boost_status_o
);

  localparam int W      = DataWidth;
  localparam int RB     = W - 1;          // root bits
  localparam int RW     = 2 * RB;         // radicand bits
  localparam int DotW   = 2 * W + 3;
  localparam int NeW    = 2 * W + 4;
  localparam int KW     = 2 * W + 4;
  localparam int NumW   = lbfv_pkg::num_width(W);
  localparam int DenW   = lbfv_pkg::den_width(W);
  localparam int DivLat = lbfv_pkg::div_latency(W);
  localparam int Lat    = RB + DivLat + 8;  // accept edge to result edge

  // everything a request carries past the square root
  typedef struct packed {
    lbfv_pkg::status_e     status;
    logic signed [W-1:0]   e;
    logic [2:0][W-1:0]     p;
    logic [W-1:0]          a;       // |frame energy|
    logic [2:0][W:0]       pf;      // frame momentum folded by energy sign
    logic signed [DotW-1:0] dot;    // P . p
    logic signed [NeW-1:0] ne;      // A*E - P . p
  } side_t;

  // what the output stage still needs while the dividers work
  typedef struct packed {
    lbfv_pkg::status_e   status;
    logic signed [W-1:0] e;
    logic [2:0][W-1:0]   p;
  } out_t;

  // ---------------------------------------------------------------------------
  // request side: no stall source, a request is taken every cycle
  // ---------------------------------------------------------------------------
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  logic signed [W-1:0] pin [3];
  logic signed [W-1:0] fin [3];
  logic [W-1:0]        fmag [3];
  logic [W-1:0]        emag;
  logic signed [W:0]   pf_c [3];

  assign pin[0] = particle_px_i;
  assign pin[1] = particle_py_i;
  assign pin[2] = particle_pz_i;
  assign fin[0] = frame_px_i;
  assign fin[1] = frame_py_i;
  assign fin[2] = frame_pz_i;

  assign emag = frame_energy_i[W-1] ? $unsigned(-frame_energy_i) : $unsigned(frame_energy_i);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fmag[i] = fin[i][W-1] ? $unsigned(-fin[i]) : $unsigned(fin[i]);
      pf_c[i] = frame_energy_i[W-1] ? -(W+1)'(fin[i]) : (W+1)'(fin[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: squares and dot-product terms
  // ---------------------------------------------------------------------------
  logic                   v1_q;
  logic signed [W-1:0]    e1_q;
  logic signed [W-1:0]    p1_q   [3];
  logic [W-1:0]           a1_q;
  logic signed [W:0]      pf1_q  [3];
  logic [2*W-1:0]         sqf1_q [3];
  logic [2*W-1:0]         ee1_q;
  logic signed [2*W:0]    dot1_q [3];
  logic signed [2*W:0]    ea1_q;
  logic                   mz1_q;
  logic                   ez1_q;

  always_ff @(posedge clk_i) begin
    e1_q  <= particle_energy_i;
    a1_q  <= emag;
    ee1_q <= (2*W)'(emag) * (2*W)'(emag);
    ea1_q <= (2*W+1)'(particle_energy_i) * (2*W+1)'($signed({1'b0, emag}));
    mz1_q <= (frame_px_i == '0) && (frame_py_i == '0) && (frame_pz_i == '0);
    ez1_q <= frame_energy_i == '0;
    for (int i = 0; i < 3; i++) begin
      p1_q[i]   <= pin[i];
      pf1_q[i]  <= pf_c[i];
      sqf1_q[i] <= (2*W)'(fmag[i]) * (2*W)'(fmag[i]);
      dot1_q[i] <= (2*W+1)'(pf_c[i]) * (2*W+1)'(pin[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: classify the frame, form the radicand and the energy numerator
  // ---------------------------------------------------------------------------
  logic [2*W+1:0]       pp;
  logic [2*W+1:0]       rad_diff;
  lbfv_pkg::status_e    status_c;
  side_t                side2;

  assign pp       = (2*W+2)'(sqf1_q[0]) + (2*W+2)'(sqf1_q[1]) + (2*W+2)'(sqf1_q[2]);
  assign rad_diff = (2*W+2)'(ee1_q) - pp;

  always_comb begin
    // momentum-zero test takes priority over energy-zero
    if (mz1_q) begin
      status_c = lbfv_pkg::ST_MOM_ZERO;
    end else if (ez1_q) begin
      status_c = lbfv_pkg::ST_ENERGY_ZERO;
    end else if (pp >= (2*W+2)'(ee1_q)) begin
      status_c = lbfv_pkg::ST_NOT_TIMELIKE;
    end else begin
      status_c = lbfv_pkg::ST_BOOSTED;
    end
    side2.status = status_c;
    side2.e      = e1_q;
    side2.a      = a1_q;
    for (int i = 0; i < 3; i++) begin
      side2.p[i]  = p1_q[i];
      side2.pf[i] = pf1_q[i];
    end
    side2.dot = DotW'(dot1_q[0]) + DotW'(dot1_q[1]) + DotW'(dot1_q[2]);
    side2.ne  = NeW'(ea1_q) - NeW'(side2.dot);
  end

  // ---------------------------------------------------------------------------
  // integer square root of |E|^2 - P.P, one root bit per stage
  // index 0 is loaded by stage 2, index RB holds the finished root
  // ---------------------------------------------------------------------------
  logic            sr_v_q    [RB+1];
  side_t           sr_side_q [RB+1];
  logic [RB+1:0]   sr_rem_q  [RB+1];
  logic [RB-1:0]   sr_root_q [RB+1];
  logic [RW-1:0]   sr_rad_q  [RB+1];

  logic [RB+1:0]   sr_sh    [RB];
  logic [RB+1:0]   sr_trial [RB];
  logic            sr_ge    [RB];

  always_comb begin
    for (int k = 0; k < RB; k++) begin
      sr_sh[k]    = {sr_rem_q[k][RB-1:0], sr_rad_q[k][RW-1 -: 2]};
      sr_trial[k] = {sr_root_q[k], 2'b01};
      sr_ge[k]    = sr_sh[k] >= sr_trial[k];
    end
  end

  always_ff @(posedge clk_i) begin
    sr_side_q[0] <= side2;
    sr_rem_q[0]  <= '0;
    sr_root_q[0] <= '0;
    sr_rad_q[0]  <= rad_diff[RW-1:0];
    for (int k = 0; k < RB; k++) begin
      sr_side_q[k+1] <= sr_side_q[k];
      sr_rem_q[k+1]  <= sr_ge[k] ? sr_sh[k] - sr_trial[k] : sr_sh[k];
      sr_root_q[k+1] <= {sr_root_q[k][RB-2:0], sr_ge[k]};
      sr_rad_q[k+1]  <= {sr_rad_q[k][RW-3:0], 2'b00};
    end
  end

  // ---------------------------------------------------------------------------
  // stages 3 to 7: build divisor and momentum numerators
  //   dv = m*(A+m), k = P.p - E*(A+m), num_i = p_i*dv + k*P_i
  // wide products are split into a low W-bit part and a high part of the divisor or of k
  // ---------------------------------------------------------------------------
  logic                   v3_q, v4_q, v5_q, v6_q, v7_q;
  side_t                  side3_q, side4_q, side5_q, side6_q, side7_q;
  logic [RB-1:0]          sq3_q, sq4_q, sq5_q, sq6_q, sq7_q;
  logic [W-1:0]           as3_q;
  logic [DenW-1:0]        dv4_q, dv5_q, dv6_q, dv7_q;
  logic signed [2*W:0]    eas4_q;
  logic signed [KW-1:0]   k5_q;
  logic signed [2*W:0]    pdl5_q [3];
  logic signed [2*W-1:0]  pdh5_q [3];
  logic signed [3*W:0]    pdv6_q [3];
  logic signed [2*W+1:0]  klp6_q [3];
  logic signed [2*W+4:0]  khp6_q [3];
  logic signed [NumW-1:0] num7_q [3];

  always_ff @(posedge clk_i) begin
    // stage 3
    side3_q <= sr_side_q[RB];
    sq3_q   <= sr_root_q[RB];
    as3_q   <= sr_side_q[RB].a + W'(sr_root_q[RB]);
    // stage 4
    side4_q <= side3_q;
    sq4_q   <= sq3_q;
    dv4_q   <= DenW'(sq3_q) * DenW'(as3_q);
    eas4_q  <= (2*W+1)'(side3_q.e) * (2*W+1)'($signed({1'b0, as3_q}));
    // stage 5
    side5_q <= side4_q;
    sq5_q   <= sq4_q;
    dv5_q   <= dv4_q;
    k5_q    <= KW'(side4_q.dot) - KW'(eas4_q);
    for (int i = 0; i < 3; i++) begin
      pdl5_q[i] <= (2*W+1)'($signed(side4_q.p[i]))
                 * (2*W+1)'($signed({1'b0, dv4_q[W-1:0]}));
      pdh5_q[i] <= (2*W)'($signed(side4_q.p[i]))
                 * (2*W)'($signed({1'b0, dv4_q[DenW-1:W]}));
    end
    // stage 6
    side6_q <= side5_q;
    sq6_q   <= sq5_q;
    dv6_q   <= dv5_q;
    for (int i = 0; i < 3; i++) begin
      pdv6_q[i] <= ((3*W+1)'(pdh5_q[i]) << W) + (3*W+1)'(pdl5_q[i]);
      klp6_q[i] <= (2*W+2)'($signed({1'b0, k5_q[W-1:0]}))
                 * (2*W+2)'($signed(side5_q.pf[i]));
      khp6_q[i] <= (2*W+5)'($signed(k5_q[KW-1:W]))
                 * (2*W+5)'($signed(side5_q.pf[i]));
    end
    // stage 7
    side7_q <= side6_q;
    sq7_q   <= sq6_q;
    dv7_q   <= dv6_q;
    for (int i = 0; i < 3; i++) begin
      num7_q[i] <= NumW'(pdv6_q[i]) + (NumW'(khp6_q[i]) << W) + NumW'(klp6_q[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // rounding dividers: energy by m, momenta by dv
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] quo_e;
  logic signed [W-1:0] quo_p [3];

  lbfv_div #(
    .DataWidth (W)
  ) u_div_e (
    .clk_i (clk_i),
    .num_i (NumW'(side7_q.ne)),
    .den_i (DenW'(sq7_q)),
    .quo_o (quo_e)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div_p
    lbfv_div #(
      .DataWidth (W)
    ) u_div_p (
      .clk_i (clk_i),
      .num_i (num7_q[i]),
      .den_i (dv7_q),
      .quo_o (quo_p[i])
    );
  end

  // status and pass-through values wait alongside the dividers
  logic od_v_q [DivLat];
  out_t od_q   [DivLat];

  always_ff @(posedge clk_i) begin
    od_q[0].status <= side7_q.status;
    od_q[0].e      <= side7_q.e;
    od_q[0].p      <= side7_q.p;
    for (int k = 1; k < DivLat; k++) begin
      od_q[k] <= od_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // output register: boosted values or the untouched particle
  // ---------------------------------------------------------------------------
  logic                out_v_q;
  logic signed [W-1:0] out_e_q;
  logic signed [W-1:0] out_p_q [3];
  lbfv_pkg::status_e   out_st_q;

  always_ff @(posedge clk_i) begin
    out_st_q <= od_q[DivLat-1].status;
    if (od_q[DivLat-1].status == lbfv_pkg::ST_BOOSTED) begin
      out_e_q <= quo_e;
      for (int i = 0; i < 3; i++) out_p_q[i] <= quo_p[i];
    end else begin
      out_e_q <= od_q[DivLat-1].e;
      for (int i = 0; i < 3; i++) out_p_q[i] <= $signed(od_q[DivLat-1].p[i]);
    end
  end

  // valid bits for every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= RB; k++) sr_v_q[k] <= 1'b0;
      for (int k = 0; k < DivLat; k++) od_v_q[k] <= 1'b0;
    end else begin
      v1_q      <= accept;
      sr_v_q[0] <= v1_q;
      for (int k = 0; k < RB; k++) sr_v_q[k+1] <= sr_v_q[k];
      v3_q      <= sr_v_q[RB];
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      od_v_q[0] <= v7_q;
      for (int k = 1; k < DivLat; k++) od_v_q[k] <= od_v_q[k-1];
      out_v_q   <= od_v_q[DivLat-1];
    end
  end

  assign valid_o          = out_v_q;
  assign boosted_energy_o = out_e_q;
  assign boosted_px_o     = out_p_q[0];
  assign boosted_py_o     = out_p_q[1];
  assign boosted_pz_o     = out_p_q[2];
  assign boost_status_o   = out_st_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `LBFV_ASSERT_NXT(a_last_stage_to_out, clk_i, rst_ni, od_v_q[DivLat-1], valid_o)
  `LBFV_ASSERT_IMP(a_result_had_request, clk_i, rst_ni, valid_o, $past(start_i, Lat))
  `LBFV_ASSERT_IMP(a_mom_zero_frame, clk_i, rst_ni, valid_o && boost_status_o == lbfv_pkg::ST_MOM_ZERO, $past(frame_px_i, Lat) == '0 && $past(frame_py_i, Lat) == '0 && $past(frame_pz_i, Lat) == '0)
  `LBFV_ASSERT_IMP(a_mom_zero_pass, clk_i, rst_ni, valid_o && boost_status_o == lbfv_pkg::ST_MOM_ZERO, boosted_energy_o == $past(particle_energy_i, Lat) && boosted_pz_o == $past(particle_pz_i, Lat))
  `LBFV_ASSERT_IMP(a_energy_zero_frame, clk_i, rst_ni, valid_o && boost_status_o == lbfv_pkg::ST_ENERGY_ZERO, $past(frame_energy_i, Lat) == '0)

endmodule

[hdl/lbfv_div.sv]
module lbfv_div #(
  parameter int DataWidth = lbfv_pkg::DATA_WIDTH_DEF
) (
  input  logic                                           clk_i,
  input  logic signed [lbfv_pkg::num_width(DataWidth)-1:0] num_i,
  input  logic [lbfv_pkg::den_width(DataWidth)-1:0]        den_i,
  output logic signed [DataWidth-1:0]                      quo_o
);

  localparam int W    = DataWidth;
  localparam int NumW = lbfv_pkg::num_width(W);
  localparam int DenW = lbfv_pkg::den_width(W);
  localparam int QB   = W - 1;
  localparam int MW   = NumW + 1;

  logic [NumW-1:0] num_mag;

  logic            neg_a_q;
  logic [MW-1:0]   rem_a_q;
  logic [DenW-1:0] den_a_q;

  logic            neg_q   [QB+1];
  logic            sat_q   [QB+1];
  logic [MW-1:0]   rem_q   [QB+1];
  logic [DenW-1:0] den_q   [QB+1];
  logic [QB-1:0]   quo_s_q [QB+1];

  logic [MW-1:0]   trial [QB];
  logic            ge    [QB];

  logic signed [W-1:0] quo_q;

  assign num_mag = num_i[NumW-1] ? $unsigned(-num_i) : $unsigned(num_i);

  // magnitude plus half the divisor gives rounding to nearest, ties away from zero
  always_ff @(posedge clk_i) begin
    neg_a_q <= num_i[NumW-1];
    rem_a_q <= MW'(num_mag) + MW'(den_i >> 1);
    den_a_q <= den_i;
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = MW'(den_q[k]) << (QB - 1 - k);
      ge[k]    = rem_q[k] >= trial[k];
    end
  end

  // one quotient bit per stage, most significant first
  always_ff @(posedge clk_i) begin
    neg_q[0]   <= neg_a_q;
    sat_q[0]   <= rem_a_q >= (MW'(den_a_q) << QB);
    rem_q[0]   <= rem_a_q;
    den_q[0]   <= den_a_q;
    quo_s_q[0] <= '0;
    for (int k = 0; k < QB; k++) begin
      neg_q[k+1]   <= neg_q[k];
      sat_q[k+1]   <= sat_q[k];
      den_q[k+1]   <= den_q[k];
      rem_q[k+1]   <= ge[k] ? rem_q[k] - trial[k] : rem_q[k];
      quo_s_q[k+1] <= {quo_s_q[k][QB-2:0], ge[k]};
    end
    if (sat_q[QB]) begin
      quo_q <= neg_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else if (neg_q[QB]) begin
      quo_q <= -$signed({1'b0, quo_s_q[QB]});
    end else begin
      quo_q <= $signed({1'b0, quo_s_q[QB]});
    end
  end

  assign quo_o = quo_q;

endmodule
